// ----- rtl/core/dhkt_pkg.sv -----
// ----------------------------------------------------------------------------
// dhkt_pkg
// Shared widths, operation and status codes, FSM states and store controls
// for the double-hashing key table.
// ----------------------------------------------------------------------------
package dhkt_pkg;

	localparam int KIND_W          = 2;
	localparam int KEY_W           = 48;
	localparam int TAG_W           = 32;
	localparam int STATUS_W        = 2;
	localparam int SLOT_W          = 5;
	localparam int STEP_W          = 4;
	localparam int STEP_BASE       = 8;
	localparam int CHUNK_W         = 8;
	localparam int KEY_CHUNKS      = KEY_W / CHUNK_W;
	localparam int DEF_TABLE_SLOTS = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PRB_RD,
		ST_PRB_CHK,
		ST_DEL_RD,
		ST_DEL_CHK
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic key_we;
		logic tag_we;
	} store_ctl_t;

endpackage

// ----- rtl/core/dhkt_mod_unit.sv -----
// ----------------------------------------------------------------------------
// dhkt_mod_unit
// Key mod TABLE_SLOTS in registered steps: byte-weighted fold, reciprocal
// multiply, then one correcting subtract. done marks the cycle rem is valid.
// ----------------------------------------------------------------------------
module dhkt_mod_unit #(
	parameter int TABLE_SLOTS = dhkt_pkg::DEF_TABLE_SLOTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dhkt_pkg::KEY_W-1:0] key,
	output logic                       done,
	output logic [$clog2(TABLE_SLOTS)-1:0] rem
);
	import dhkt_pkg::*;

	localparam int RW    = $clog2(TABLE_SLOTS);
	// folded sum stays below KEY_CHUNKS * 255 * TABLE_SLOTS
	localparam int SUM_W = $clog2(KEY_CHUNKS * ((1 << CHUNK_W) - 1) * TABLE_SLOTS);
	localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / 64'(TABLE_SLOTS));
	localparam logic [SUM_W-1:0] SLOTS_W = SUM_W'(TABLE_SLOTS);
	localparam logic [RW:0]      SLOTS_R = (RW+1)'(TABLE_SLOTS);

	// 2^(CHUNK_W*j) mod TABLE_SLOTS
	function automatic logic [RW-1:0] chunk_weight(input int j);
		logic [63:0] p;
		p = (64'd1 << (CHUNK_W * j)) % 64'(TABLE_SLOTS);
		return RW'(p);
	endfunction

	logic                 v_s1, v_s2;
	logic                 done_q;
	logic [SUM_W-1:0]     chunk_sum;
	logic [SUM_W-1:0]     sum_s1, sum_s2;
	logic [2*SUM_W-1:0]   prod_s2;
	logic [SUM_W-1:0]     quot;
	logic [SUM_W-1:0]     r_est;
	logic [RW:0]          r_low;
	logic [RW:0]          r_sub;
	logic [RW-1:0]        rem_d;
	logic [RW-1:0]        rem_q;

	always_comb begin
		chunk_sum = '0;
		for (int j = 0; j < KEY_CHUNKS; j++) begin
			chunk_sum = chunk_sum + SUM_W'(key[j*CHUNK_W +: CHUNK_W]) *
				SUM_W'(chunk_weight(j));
		end
	end

	// quotient estimate is exact or one low, so the remainder is below 2N
	always_comb begin
		quot  = prod_s2[2*SUM_W-1 -: SUM_W];
		r_est = sum_s2 - quot * SLOTS_W;
		r_low = r_est[RW:0];
		r_sub = r_low - SLOTS_R;
		rem_d = (r_low >= SLOTS_R) ? r_sub[RW-1:0] : r_low[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1  <= chunk_sum;
		sum_s2  <= sum_s1;
		prod_s2 <= (2*SUM_W)'(sum_s1) * (2*SUM_W)'(RECIP);
		rem_q   <= rem_d;
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/core/dhkt_store.sv -----
// ----------------------------------------------------------------------------
// dhkt_store
// Key and tag memories: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dhkt_store #(
	parameter int TABLE_SLOTS = dhkt_pkg::DEF_TABLE_SLOTS
) (
	input  logic                           clk,
	input  dhkt_pkg::store_ctl_t           ctl,
	input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
	input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
	input  logic [dhkt_pkg::KEY_W-1:0]     wr_key,
	input  logic [dhkt_pkg::TAG_W-1:0]     wr_tag,
	output logic [dhkt_pkg::KEY_W-1:0]     rd_key,
	output logic [dhkt_pkg::TAG_W-1:0]     rd_tag
);
	import dhkt_pkg::*;

	logic [KEY_W-1:0] key_mem [TABLE_SLOTS];
	logic [TAG_W-1:0] tag_mem [TABLE_SLOTS];
	logic [KEY_W-1:0] rd_key_q;
	logic [TAG_W-1:0] rd_tag_q;

	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (ctl.rd_en) begin
			rd_key_q <= key_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tag_we) begin
			tag_mem[wr_addr] <= wr_tag;
		end
		if (ctl.rd_en) begin
			rd_tag_q <= tag_mem[rd_addr];
		end
	end

	assign rd_key = rd_key_q;
	assign rd_tag = rd_tag_q;

endmodule

// ----- rtl/core/double_hash_key_table_top.sv -----
// ----------------------------------------------------------------------------
// double_hash_key_table_top
// Open-addressing key table with double hashing: insert, lookup, delete.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (kind, key, record_tag) is taken at a clock edge where
//   start is high and busy is low. Each command yields one result word
//   (status, slot, found_tag), shown for one cycle with done high. The
//   receiver cannot stall; results are never held.
// Sequence from the accepting edge to the cycle done is high:
//   key zero or unused kind: done is high in the cycle after the accepting edge.
//   insert / lookup: p = slots probed (1..TABLE_SLOTS), one check each.
//     The home-slot hash (key mod TABLE_SLOTS) is a three-stage pipeline
//     whose result is taken in ST_HASH, then one memory read issues,
//     then one slot is checked per cycle while the read of the next probe
//     slot is already in flight.
//   delete: a full scan, one slot read per cycle, matches are written
//     back as empty behind the read pointer.
//   One command at a time; busy falls in the cycle done is shown, so the
//   next command may be taken then.
// Reset: a clearing pass writes every key slot empty, busy high
//   throughout. Tags are not cleared.
// ----------------------------------------------------------------------------
module double_hash_key_table_top #(
	parameter int TABLE_SLOTS = dhkt_pkg::DEF_TABLE_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dhkt_pkg::KIND_W-1:0]   kind,
	input  logic [dhkt_pkg::KEY_W-1:0]    key,
	input  logic [dhkt_pkg::TAG_W-1:0]    record_tag,
	output logic                          done,
	output logic [dhkt_pkg::STATUS_W-1:0] status,
	output logic [dhkt_pkg::SLOT_W-1:0]   slot,
	output logic [dhkt_pkg::TAG_W-1:0]    found_tag
);
	import dhkt_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam logic [IW:0]   SLOTS_X  = (IW+1)'(TABLE_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

	state_t state_q, state_d;

	// command payload, latched on accept
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [TAG_W-1:0]  tag_q;
	logic [STEP_W-1:0] step_q;

	// walk state
	logic [IW-1:0] home_q, home_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] last_q, last_d;
	logic          hit_q, hit_d;

	// result word
	logic                done_q, done_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [SLOT_W-1:0]   slot_q;
	logic [IW-1:0]       res_idx_d;
	logic [IW+SLOT_W-1:0] res_idx_x;
	logic [TAG_W-1:0]    found_tag_q, found_tag_d;

	// store interface
	store_ctl_t       ctl;
	logic [IW-1:0]    rd_addr;
	logic [IW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [KEY_W-1:0] rd_key;
	logic [TAG_W-1:0] rd_tag;

	// hash unit
	logic          mod_start;
	logic          mod_done;
	logic [IW-1:0] home_rem;

	logic          accept;
	logic          cmd_nop;
	logic [IW:0]   nsum;
	logic [IW:0]   nsum_wrap;
	logic [IW-1:0] next_idx;
	logic          key_hit;
	logic          key_empty;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign cmd_nop = (key == '0) || (kind == KIND_UNUSED);
	assign mod_start = accept && !cmd_nop && (kind != KIND_DELETE);

	// next probe slot: idx + step < 2N, one conditional subtract
	assign nsum      = {1'b0, idx_q} + (IW+1)'(step_q);
	assign nsum_wrap = nsum - SLOTS_X;
	assign next_idx  = (nsum >= SLOTS_X) ? nsum_wrap[IW-1:0] : nsum[IW-1:0];

	assign key_hit   = (rd_key == key_q);
	assign key_empty = (rd_key == '0);

	dhkt_mod_unit #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (key),
		.done   (mod_done),
		.rem    (home_rem)
	);

	dhkt_store #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_tag  (tag_q),
		.rd_key  (rd_key),
		.rd_tag  (rd_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		rd_addr     = idx_q;
		wr_addr     = idx_q;
		wr_key      = '0;
		home_d      = home_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		last_d      = last_q;
		hit_d       = hit_q;
		done_d      = 1'b0;
		status_d    = status_q;
		res_idx_d   = '0;
		found_tag_d = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.key_we = 1'b1;
				wr_addr    = cnt_q;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd_nop) begin
						done_d   = 1'b1;
						status_d = STAT_MISS;
					end else if (kind == KIND_DELETE) begin
						cnt_d   = '0;
						last_d  = '0;
						hit_d   = 1'b0;
						state_d = ST_DEL_RD;
					end else begin
						state_d = ST_HASH;
					end
				end
			end
			ST_HASH: begin
				if (mod_done) begin
					home_d  = home_rem;
					idx_d   = home_rem;
					state_d = ST_PRB_RD;
				end
			end
			ST_PRB_RD: begin
				ctl.rd_en = 1'b1;
				rd_addr   = idx_q;
				state_d   = ST_PRB_CHK;
			end
			ST_PRB_CHK: begin
				if (key_empty) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
					if (kind_q == KIND_INSERT) begin
						ctl.key_we = 1'b1;
						ctl.tag_we = 1'b1;
						wr_addr    = idx_q;
						wr_key     = key_q;
						status_d   = STAT_DONE;
						res_idx_d  = idx_q;
					end else begin
						status_d = STAT_MISS;
					end
				end else if ((kind_q == KIND_LOOKUP) && key_hit) begin
					done_d      = 1'b1;
					state_d     = ST_IDLE;
					status_d    = STAT_DONE;
					res_idx_d   = idx_q;
					found_tag_d = rd_tag;
				end else if (next_idx == home_q) begin
					// chain wrapped to home: full on insert, miss on lookup
					done_d   = 1'b1;
					state_d  = ST_IDLE;
					status_d = (kind_q == KIND_INSERT) ? STAT_FULL : STAT_MISS;
				end else begin
					idx_d     = next_idx;
					ctl.rd_en = 1'b1;
					rd_addr   = next_idx;
				end
			end
			ST_DEL_RD: begin
				ctl.rd_en = 1'b1;
				rd_addr   = cnt_q;
				state_d   = ST_DEL_CHK;
			end
			ST_DEL_CHK: begin
				// write-back at cnt, read already one slot ahead
				if (key_hit) begin
					ctl.key_we = 1'b1;
					wr_addr    = cnt_q;
					hit_d      = 1'b1;
					last_d     = cnt_q;
				end
				if (cnt_q == LAST_IDX) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
					cnt_d   = '0;
					if (key_hit) begin
						status_d  = STAT_DONE;
						res_idx_d = cnt_q;
					end else if (hit_q) begin
						status_d  = STAT_DONE;
						res_idx_d = last_q;
					end else begin
						status_d = STAT_MISS;
					end
				end else begin
					cnt_d     = cnt_q + 1'b1;
					ctl.rd_en = 1'b1;
					rd_addr   = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hit_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			hit_q  <= hit_d;
			done_q <= done_d;
		end
	end

	assign res_idx_x = (IW+SLOT_W)'(res_idx_d);

	always_ff @(posedge clk) begin
		home_q      <= home_d;
		idx_q       <= idx_d;
		last_q      <= last_d;
		status_q    <= status_d;
		found_tag_q <= found_tag_d;
		if (done_d) begin
			slot_q <= res_idx_x[SLOT_W-1:0];
		end
	end

	// step = 8 - key mod 8, range 1..8
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= key;
			tag_q  <= record_tag;
			step_q <= STEP_W'(STEP_BASE) - STEP_W'(key[2:0]);
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign found_tag = found_tag_q;

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == STAT_FULL)) |-> (kind_q == KIND_INSERT))
		else $error("table-full result on a non-insert command");

	a_tag_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (found_tag_q != '0)) |->
		((status_q == STAT_DONE) && (kind_q == KIND_LOOKUP)))
		else $error("found_tag set outside a successful lookup");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRB_CHK) |-> (({1'b0, idx_q} < SLOTS_X) && ({1'b0, home_q} < SLOTS_X)))
		else $error("probe index out of table range");

	a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_HASH))
		else $error("hash result outside the hash state");

endmodule
